// ===== hw/rtl/xor_sprite_row_framebuffer_macros.svh =====
// Assertion macros shared by the sprite framebuffer RTL.
`ifndef XOR_SPRITE_ROW_FRAMEBUFFER_MACROS_SVH
`define XOR_SPRITE_ROW_FRAMEBUFFER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define XSRF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define XSRF_NEVER(label, bad, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) else $error(msg);

`endif

// ===== hw/rtl/xsrf_pkg.sv =====
// Constants, types and index helpers for the sprite framebuffer.
package xsrf_pkg;

  // Screen geometry and packing.
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int PIXEL_BITS    = 8;
  localparam int ROW_PITCH     = (SCREEN_WIDTH + PIXEL_BITS - 1) / PIXEL_BITS;
  localparam int ROW_BITS      = ROW_PITCH * PIXEL_BITS;
  localparam int STORE_DEPTH   = ROW_PITCH * SCREEN_HEIGHT;

  // Index widths.
  localparam int X_W    = $clog2(SCREEN_WIDTH);
  localparam int ROW_AW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int COL_AW = (ROW_PITCH > 1) ? $clog2(ROW_PITCH) : 1;

  // Command codes.
  typedef enum logic [1:0] {
    ACT_DRAW  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // A packed byte address split into row and byte column.
  typedef struct packed {
    logic [ROW_AW-1:0] row;
    logic [COL_AW-1:0] col;
  } addr_split_t;

  // Column modulo screen width by restoring subtraction.
  function automatic logic [X_W-1:0] wrap_x(input logic [7:0] v);
    logic [11:0] r;
    r = 12'(v);
    for (int k = 4; k >= 0; k--) begin
      if (r >= (12'(SCREEN_WIDTH) << k)) begin
        r = r - (12'(SCREEN_WIDTH) << k);
      end
    end
    return r[X_W-1:0];
  endfunction

  // Row modulo screen height by restoring subtraction.
  function automatic logic [ROW_AW-1:0] wrap_y(input logic [7:0] v);
    logic [15:0] r;
    r = 16'(v);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (16'(SCREEN_HEIGHT) << k)) begin
        r = r - (16'(SCREEN_HEIGHT) << k);
      end
    end
    return r[ROW_AW-1:0];
  endfunction

  // Byte address to row and byte column, dividing by the row pitch.
  function automatic addr_split_t split_addr(input logic [7:0] addr);
    logic [15:0] r;
    logic [7:0]  q;
    addr_split_t s;
    r = 16'(addr);
    q = '0;
    for (int k = 7; k >= 0; k--) begin
      if (r >= (16'(ROW_PITCH) << k)) begin
        r    = r - (16'(ROW_PITCH) << k);
        q[k] = 1'b1;
      end
    end
    s.row = q[ROW_AW-1:0];
    s.col = r[COL_AW-1:0];
    return s;
  endfunction

endpackage

// ===== hw/rtl/xor_sprite_row_framebuffer.sv =====
// Top level of the XOR sprite framebuffer with row-wide pixel memory.
//
// Usage: a command is transferred at a rising edge where start is high and
// busy is low. in_action selects draw sprite row, clear screen or read one
// packed byte; unused codes change nothing and answer with zeros.
// Every command yields exactly one result, shown on out_collision and
// out_read_data for one cycle while out_strobe is high. The receiver cannot
// stall; each result must be taken in its strobe cycle.
// Sequence: the transfer edge reads one row word from the pixel memory; in
// the next cycle (busy high) a draw modifies the word and writes it back;
// the result strobe follows in the cycle after that. A new command can be
// transferred during the strobe cycle, but not while a command is busy.
// This is set by the read-modify-write of one row word through the memory's
// single registered read port; busy interlocks the next read behind the write.
// Clear takes the same sequence: per-row valid bits are dropped at once.
// Reset (rst_n low, synchronous) darkens the screen by clearing the valid
// bits, returns the sequencer to idle and drops any pending strobe.
module xor_sprite_row_framebuffer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_action,
  input  logic [7:0]               in_x_position,
  input  logic [7:0]               in_y_position,
  input  logic [7:0]               in_sprite_row,
  input  logic [7:0]               in_read_address,
  output logic                     out_strobe,
  output logic                     out_collision,
  output logic [7:0]               out_read_data
);
  import xsrf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    accept;
  action_t                 act_in;
  action_t                 act_r;
  logic [X_W-1:0]          x_r;
  logic [7:0]              sprite_r;
  logic [ROW_AW-1:0]       row_r;
  logic [COL_AW-1:0]       bcol_r;
  logic                    in_range_r;

  logic [ROW_BITS-1:0]     mem [SCREEN_HEIGHT];
  logic [ROW_BITS-1:0]     rd_word_r;
  logic [SCREEN_HEIGHT-1:0] valid_r;

  logic [X_W-1:0]          x_wrap;
  logic [ROW_AW-1:0]       y_wrap;
  addr_split_t             split;
  logic                    addr_ok;
  logic [ROW_AW-1:0]       rd_row;

  logic [ROW_BITS-1:0]     old_word;
  logic [SCREEN_WIDTH+7:0] shifted;
  logic [SCREEN_WIDTH-1:0] pix;
  logic [ROW_BITS-1:0]     row_mask;
  logic [ROW_BITS-1:0]     new_word;
  logic [ROW_BITS-1:0]     byte_sh;
  logic                    hit;
  logic [7:0]              rd_byte;

  logic                    out_strobe_r;
  logic                    out_collision_r;
  logic [7:0]              out_read_data_r;

  // Handshake and sequencer.
  assign busy   = (state_r == ST_EXEC);
  assign accept = start && (state_r == ST_IDLE);
  assign act_in = action_t'(in_action);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Address decode on the transfer edge: wrapped position or split byte address.
  always_comb begin
    x_wrap  = wrap_x(in_x_position);
    y_wrap  = wrap_y(in_y_position);
    split   = split_addr(in_read_address);
    addr_ok = (16'(in_read_address) < 16'(STORE_DEPTH));
    if (act_in == ACT_READ) begin
      rd_row = addr_ok ? split.row : '0;
    end else begin
      rd_row = y_wrap;
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r      <= act_in;
      x_r        <= x_wrap;
      sprite_r   <= in_sprite_row;
      row_r      <= rd_row;
      bcol_r     <= split.col;
      in_range_r <= addr_ok;
    end
  end

  // Pixel memory: one row word per entry, registered read, write-back of a draw in EXEC.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word_r <= mem[rd_row];
    end
    if ((state_r == ST_EXEC) && (act_r == ACT_DRAW)) begin
      mem[row_r] <= new_word;
    end
  end

  // Row valid bits; a row that is not valid reads as dark.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (state_r == ST_EXEC) begin
      if (act_r == ACT_CLEAR) begin
        valid_r <= '0;
      end else if (act_r == ACT_DRAW) begin
        valid_r[row_r] <= 1'b1;
      end
    end
  end

  // Sprite placement: shift into the row, then fold the spill back to column 0.
  always_comb begin
    old_word = valid_r[row_r] ? rd_word_r : '0;
    shifted  = {sprite_r, SCREEN_WIDTH'(0)} >> x_r;
    pix      = shifted[SCREEN_WIDTH+7:8]
             | (SCREEN_WIDTH'(shifted[7:0]) << (SCREEN_WIDTH - PIXEL_BITS));
    row_mask = ROW_BITS'(pix) << (ROW_BITS - SCREEN_WIDTH);
    new_word = old_word ^ row_mask;
    hit      = |(old_word & row_mask);
    byte_sh  = old_word << (PIXEL_BITS * int'(bcol_r));
    rd_byte  = byte_sh[ROW_BITS-1 -: 8];
  end

  // Result register, strobed for one cycle after EXEC.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      out_collision_r <= (act_r == ACT_DRAW) && hit;
      out_read_data_r <= ((act_r == ACT_READ) && in_range_r) ? rd_byte : 8'd0;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_collision = out_collision_r;
  assign out_read_data = out_read_data_r;

  // Checks on the sequencer and result path.
`include "xor_sprite_row_framebuffer_macros.svh"
  `XSRF_ASSERT(a_accept_busy, (start && !busy) |=> busy, "transfer did not enter busy")
  `XSRF_ASSERT(a_busy_strobe, busy |=> (out_strobe && !busy), "busy cycle gave no result")
  `XSRF_ASSERT(a_hit_draw, (out_strobe && out_collision) |-> ($past(act_r) == ACT_DRAW), "collision on non-draw")
  `XSRF_NEVER(a_idle_strobe, out_strobe && $past(!busy), "result without a busy cycle")

endmodule

// ===== tb/xsrf_frame_model_pkg.sv =====
// Scoreboard for the sprite framebuffer: a pixel store model and the queue of answers it predicts.
`timescale 1ns / 1ps
package xsrf_frame_model_pkg;
  import xsrf_pkg::*;

  // One result as the block should present it.
  typedef struct {
    bit       collision;
    bit [7:0] read_data;
  } frame_answer_t;

  class frame_scoreboard;
    bit [7:0]      pixels [STORE_DEPTH];
    frame_answer_t pending_answers [$];
    int            mismatches;

    function new();
      mismatches = 0;
      darken_screen();
    endfunction

    function void darken_screen();
      foreach (pixels[i]) pixels[i] = 8'h00;
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction

    // XOR one sprite row into the store; the spill past the right edge wraps
    // to the left edge of the same row.
    function bit xor_sprite_row(bit [7:0] x, bit [7:0] y, bit [7:0] sprite);
      int       col0;
      int       row;
      int       col;
      int       idx;
      bit [7:0] mask;
      bit       hit;
      col0 = int'(x) % SCREEN_WIDTH;
      row  = int'(y) % SCREEN_HEIGHT;
      hit  = 1'b0;
      for (int i = 0; i < PIXEL_BITS; i++) begin
        if (sprite[7 - i]) begin
          col  = (col0 + i) % SCREEN_WIDTH;
          idx  = row * ROW_PITCH + col / PIXEL_BITS;
          if (idx < STORE_DEPTH) begin
            mask = 8'h80 >> (col % PIXEL_BITS);
            if ((pixels[idx] & mask) != 8'h00) hit = 1'b1;
            pixels[idx] = pixels[idx] ^ mask;
          end
        end
      end
      return hit;
    endfunction

    // Called for every command transfer: update the store and queue the answer.
    function void note_command(action_t act, bit [7:0] x, bit [7:0] y, bit [7:0] sprite,
                               bit [7:0] addr);
      frame_answer_t ans;
      ans.collision = 1'b0;
      ans.read_data = 8'h00;
      case (act)
        ACT_DRAW:  ans.collision = xor_sprite_row(x, y, sprite);
        ACT_CLEAR: darken_screen();
        ACT_READ: begin
          if (int'(addr) < STORE_DEPTH) ans.read_data = pixels[addr];
        end
        default: ;
      endcase
      pending_answers.push_back(ans);
    endfunction

    // Called for every result strobe: compare with the oldest answer.
    function void check_result(bit collision, bit [7:0] read_data);
      frame_answer_t ans;
      if (pending_answers.size() == 0) begin
        $error("result with no command outstanding: collision %0d, read_data 0x%02h",
               collision, read_data);
        mismatches++;
        return;
      end
      ans = pending_answers.pop_front();
      if (collision !== ans.collision) begin
        $error("collision: expected %0d, actual %0d", ans.collision, collision);
        mismatches++;
      end
      if (read_data !== ans.read_data) begin
        $error("read_data: expected 0x%02h, actual 0x%02h", ans.read_data, read_data);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== tb/xor_sprite_row_framebuffer_tb.sv =====
// Testbench top for the XOR sprite framebuffer: stimulus, monitors and end of run.
`timescale 1ns / 1ps
module xor_sprite_row_framebuffer_tb;
  import xsrf_pkg::*;
  import xsrf_frame_model_pkg::*;

  localparam int COMMAND_TARGET = 1300;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_action;
  logic [7:0] in_x_position;
  logic [7:0] in_y_position;
  logic [7:0] in_sprite_row;
  logic [7:0] in_read_address;
  logic       out_strobe;
  logic       out_collision;
  logic [7:0] out_read_data;

  frame_scoreboard sb;
  int              commands_sent;

  xor_sprite_row_framebuffer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_x_position   (in_x_position),
    .in_y_position   (in_y_position),
    .in_sprite_row   (in_sprite_row),
    .in_read_address (in_read_address),
    .out_strobe      (out_strobe),
    .out_collision   (out_collision),
    .out_read_data   (out_read_data)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Monitor: results are checked before the command of the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_collision, out_read_data);
      if (start && !busy) begin
        sb.note_command(action_t'(in_action), in_x_position, in_y_position,
                        in_sprite_row, in_read_address);
      end
    end
  end

  // Present one command at the falling edge and hold it until its transfer.
  task automatic send_command(action_t act, logic [7:0] x, logic [7:0] y,
                              logic [7:0] sprite, logic [7:0] addr);
    @(negedge clk);
    start           <= 1'b1;
    in_action       <= act;
    in_x_position   <= x;
    in_y_position   <= y;
    in_sprite_row   <= sprite;
    in_read_address <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    commands_sent++;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_drained();
    int waited;
    waited = 0;
    idle_cycles(1);
    while (sb.pending() != 0 && waited < 500) begin
      @(negedge clk);
      waited++;
    end
  endtask

  function automatic logic [7:0] random_x();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, SCREEN_WIDTH - 1));
  endfunction

  function automatic logic [7:0] byte_address(logic [7:0] x, logic [7:0] y);
    return 8'((int'(y) % SCREEN_HEIGHT) * ROW_PITCH + (int'(x) % SCREEN_WIDTH) / PIXEL_BITS);
  endfunction

  // One random command, or a whole sprite: draw its rows, read them back,
  // then draw it again to erase it.
  task automatic random_command();
    int         pick;
    int         rows;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sprite_bits [6];
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_command(ACT_DRAW, random_x(), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 70) begin
      send_command(ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 73) begin
      send_command(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 78) begin
      send_command(ACT_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      x    = random_x();
      y    = 8'($urandom);
      rows = $urandom_range(2, 6);
      for (int j = 0; j < rows; j++) begin
        sprite_bits[j] = 8'($urandom);
        send_command(ACT_DRAW, x, 8'(y + j), sprite_bits[j], 8'($urandom));
      end
      for (int j = 0; j < rows; j++) begin
        send_command(ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                     byte_address(x, 8'(y + j)));
      end
      for (int j = 0; j < rows; j++) begin
        send_command(ACT_DRAW, x, 8'(y + j), sprite_bits[j], 8'($urandom));
      end
    end
  endtask

  // Main sequence.
  initial begin
    int  burst_len;
    bit  drained_once;
    sb              = new();
    commands_sent   = 0;
    drained_once    = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = ACT_NONE;
    in_x_position   = 8'h00;
    in_y_position   = 8'h00;
    in_sprite_row   = 8'h00;
    in_read_address = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: dark screen after reset, aligned and unaligned draws, the
    // right-edge wrap within a row, coordinate wrap, erase with collision,
    // an empty sprite, the unused action code and a clear.
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, 8'd0);
    send_command(ACT_READ,  8'hFF, 8'hFF, 8'hFF, 8'd255);
    send_command(ACT_DRAW,  8'd0,  8'd0,  8'hFF, 8'h00);
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, 8'd0);
    send_command(ACT_DRAW,  8'd0,  8'd0,  8'hFF, 8'h00);
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, 8'd0);
    send_command(ACT_DRAW,  8'd60, 8'd5,  8'hFF, 8'h00);
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, byte_address(8'd60, 8'd5));
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, byte_address(8'd0, 8'd5));
    send_command(ACT_DRAW,  8'hFF, 8'hFF, 8'h81, 8'hFF);
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, 8'd255);
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, byte_address(8'd0, 8'd31));
    send_command(ACT_DRAW,  8'd3,  8'd1,  8'hA5, 8'h00);
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, byte_address(8'd0, 8'd1));
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, byte_address(8'd8, 8'd1));
    send_command(ACT_DRAW,  8'd3,  8'd1,  8'h80, 8'h00);
    send_command(ACT_DRAW,  8'd20, 8'd2,  8'h00, 8'h00);
    send_command(ACT_NONE,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, byte_address(8'd0, 8'd1));
    send_command(ACT_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, byte_address(8'd60, 8'd5));
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, 8'd255);
    send_command(ACT_DRAW,  8'd64, 8'd32, 8'h01, 8'h00);
    send_command(ACT_READ,  8'h00, 8'h00, 8'h00, 8'd0);

    // Random bursts with random gaps; some gaps are empty so bursts run together.
    while (commands_sent < COMMAND_TARGET) begin
      burst_len = $urandom_range(1, 40);
      repeat (burst_len) begin
        if (commands_sent < COMMAND_TARGET) random_command();
      end
      if (!drained_once && commands_sent > COMMAND_TARGET / 2) begin
        wait_drained();
        drained_once = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 7));
    end

    // Let the last results arrive, then keep watching for stray strobes.
    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/xsrf_pkg.sv
hw/rtl/xor_sprite_row_framebuffer.sv
tb/xsrf_frame_model_pkg.sv
tb/xor_sprite_row_framebuffer_tb.sv
